// ----- sv/count_artifact_neighbor_fill_core_macros.svh -----
// assertion macros for the count artifact neighbor fill core
`ifndef COUNT_ARTIFACT_NEIGHBOR_FILL_CORE_MACROS_SVH
`define COUNT_ARTIFACT_NEIGHBOR_FILL_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CANF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define CANF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define CANF_ASSERT_SAME(label, clk, rst, ante, cons)

`define CANF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/canf_pkg.sv -----
// shared types and constants for the count artifact neighbor fill core
package canf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int RUN_BITS = 24;
   localparam int THRESH_BITS = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_CLASS = 1'd1;

   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 16'd10000;
   localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] count_value;
      logic [SAMPLE_BITS-1:0] class_value;
      logic                   series_end;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] out_value;
      logic [RUN_BITS-1:0]    repeat_count;
      logic                   was_replaced;
      logic                   no_neighbor;
      logic                   run_overflowed;
      logic                   is_last;
   } rsp_type;

endpackage

// ----- sv/count_artifact_neighbor_fill_core.sv -----
// top level of the count artifact neighbor fill core
//
// Streams count samples and collapses each run of artifact samples (key at or above the
// threshold; key is the count value, or the class value if use-class is set) into one result
// carrying the rounded mean of the good neighbors and the run length. A request is taken
// every cycle while the queue holds fewer than two results: a good sample gives one result,
// a good sample that closes a run gives two, an artifact gives none until the run is flushed
// by a good sample or by the end of a series. Results go through a three-entry output queue
// read from its head register; one result leaves per cycle unless rsp_stall is high, and
// requests stall with two or more queued. Configuration writes take effect at the next request.
`include "count_artifact_neighbor_fill_core_macros.svh"

module count_artifact_neighbor_fill_core (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  canf_pkg::req_type                          req_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output canf_pkg::rsp_type                          rsp_data,
   input  logic                                       csr_write,
   input  logic [canf_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [canf_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);
   import canf_pkg::*;

   localparam int QUEUE_DEPTH = 3;

   logic [THRESH_BITS-1:0] threshold_ff, threshold_in;
   logic                   use_class_ff, use_class_in;

   logic [SAMPLE_BITS-1:0] prior_value_ff, prior_value_in;
   logic                   prior_valid_ff, prior_valid_in;
   logic [RUN_BITS-1:0]    run_ff, run_in;
   logic                   overflow_ff, overflow_in;

   rsp_type    slot_ff [QUEUE_DEPTH];
   rsp_type    slot_in [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;

   logic                   accept;
   logic                   pop;
   logic [SAMPLE_BITS-1:0] key;
   logic                   artifact;
   logic                   run_full;
   logic [RUN_BITS-1:0]    run_inc;
   logic                   overflow_inc;
   logic [SAMPLE_BITS:0]   pair_sum;
   logic [SAMPLE_BITS-1:0] mean_value;
   rsp_type                res0, res1;
   logic [1:0]             push_count;
   logic [1:0]             base_count;

   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (count_ff >= 2'd2);

   // configuration
   always_comb begin
      threshold_in = threshold_ff;
      use_class_in = use_class_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_wdata[THRESH_BITS-1:0];
            CSR_USE_CLASS: use_class_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // classification and run bookkeeping
   assign key          = use_class_ff ? req_data.class_value : req_data.count_value;
   assign artifact     = (key >= threshold_ff);
   assign run_full     = (run_ff == RUN_MAX);
   assign run_inc      = run_full ? run_ff : run_ff + RUN_BITS'(1);
   assign overflow_inc = overflow_ff || run_full;
   assign pair_sum     = {1'b0, prior_value_ff} + {1'b0, req_data.count_value}
                         + (SAMPLE_BITS+1)'(1);
   assign mean_value   = prior_valid_ff ? pair_sum[SAMPLE_BITS:1] : req_data.count_value;

   always_comb begin
      prior_value_in = prior_value_ff;
      prior_valid_in = prior_valid_ff;
      run_in         = run_ff;
      overflow_in    = overflow_ff;
      push_count     = 2'd0;
      res0           = '0;
      res1           = '0;
      if (accept) begin
         if (artifact) begin
            run_in      = run_inc;
            overflow_in = overflow_inc;
            if (req_data.series_end) begin
               push_count          = 2'd1;
               res0.out_value      = prior_valid_ff ? prior_value_ff : '0;
               res0.repeat_count   = run_inc;
               res0.was_replaced   = 1'b1;
               res0.no_neighbor    = !prior_valid_ff;
               res0.run_overflowed = overflow_inc;
               res0.is_last        = 1'b1;
            end
         end else begin
            prior_value_in = req_data.count_value;
            prior_valid_in = 1'b1;
            run_in         = '0;
            overflow_in    = 1'b0;
            if (run_ff != '0) begin
               push_count          = 2'd2;
               res0.out_value      = mean_value;
               res0.repeat_count   = run_ff;
               res0.was_replaced   = 1'b1;
               res0.run_overflowed = overflow_ff;
               res1.out_value      = req_data.count_value;
               res1.repeat_count   = RUN_BITS'(1);
               res1.is_last        = req_data.series_end;
            end else begin
               push_count        = 2'd1;
               res0.out_value    = req_data.count_value;
               res0.repeat_count = RUN_BITS'(1);
               res0.is_last      = req_data.series_end;
            end
         end
         if (req_data.series_end) begin
            prior_value_in = '0;
            prior_valid_in = 1'b0;
            run_in         = '0;
            overflow_in    = 1'b0;
         end
      end
   end

   // output queue, head is the result register
   always_comb begin
      base_count = count_ff - {1'b0, pop};
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i < QUEUE_DEPTH - 1)) begin
            slot_in[i] = slot_ff[(i + 1) % QUEUE_DEPTH];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if ((push_count != 2'd0) && (base_count == 2'(i))) begin
            slot_in[i] = res0;
         end
         if ((push_count == 2'd2) && (2'(base_count + 2'd1) == 2'(i))) begin
            slot_in[i] = res1;
         end
      end
      count_in = base_count + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         use_class_ff   <= 1'b0;
         prior_value_ff <= '0;
         prior_valid_ff <= 1'b0;
         run_ff         <= '0;
         overflow_ff    <= 1'b0;
         count_ff       <= 2'd0;
      end else begin
         threshold_ff   <= threshold_in;
         use_class_ff   <= use_class_in;
         prior_value_ff <= prior_value_in;
         prior_valid_ff <= prior_valid_in;
         run_ff         <= run_in;
         overflow_ff    <= overflow_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   // checks
   `CANF_ASSERT_SAME(a_room_on_accept, clock, reset, accept, count_ff <= 2'd1)
   `CANF_ASSERT_NEXT(a_drain_one, clock, reset, pop && !accept, count_ff == $past(count_ff) - 2'd1)
   `CANF_ASSERT_NEXT(a_series_clears, clock, reset, accept && req_data.series_end, run_ff == '0 && !prior_valid_ff && !overflow_ff)
   `CANF_ASSERT_SAME(a_lonely_zero, clock, reset, rsp_valid && rsp_data.no_neighbor, rsp_data.out_value == '0 && rsp_data.was_replaced)
   `CANF_ASSERT_SAME(a_overflow_full, clock, reset, overflow_ff, run_ff == RUN_MAX)

endmodule
